// File: rtl/core/dense_tensor_cell_scatter_assert.svh
// assertion macros for the dense tensor cell scatter rtl
// plain text only, no package or module dependencies
`ifndef DENSE_TENSOR_CELL_SCATTER_ASSERT_SVH
`define DENSE_TENSOR_CELL_SCATTER_ASSERT_SVH

// same-cycle implication
`define DTCS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTCS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dtcs_pkg.sv
// shared constants, codes and types of the dense tensor cell scatter
// no dependencies
package dtcs_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int CELL_DEPTH = 1024;
    localparam int VALUE_BITS = 64;

    localparam int ACT_W      = 2;
    localparam int DIM_W      = 2;
    localparam int DIMC_W     = 3;
    localparam int LABEL_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int ORDER_W    = 8;
    localparam int IDX_W      = 10;
    localparam int VAL_IN_W   = 64;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int ADDR_W     = $clog2(CELL_DEPTH);
    localparam int SPAN_W     = $clog2(CELL_DEPTH + 1);
    localparam int CNT_W      = $clog2(MAX_DIMS + 1);
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_SET   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_TWICE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADDIM  = 3'd4;
    localparam logic [STAT_W-1:0] ST_INDEX   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_3    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MAP = 3'd5;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd228;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [DIM_W-1:0]    pos;
        logic [LABEL_W-1:0]  label;
        logic [VAL_IN_W-1:0] value;
        logic [IDX_W-1:0]    index;
        logic [STAT_W-1:0]   status;
    } t_item;

    typedef struct packed {
        logic [DIMC_W-1:0]                  dims;
        logic [MAX_DIMS-1:0][SIZE_W-1:0]    sizes;
    } t_cfg;

endpackage

// File: rtl/core/dtcs_front.sv
// front end: configuration registers, item acceptance and early checks
// depends on dtcs_pkg
module dtcs_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dtcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dtcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [dtcs_pkg::ACT_W-1:0]         i_action,
    input  logic [dtcs_pkg::DIM_W-1:0]         i_dim_id,
    input  logic [dtcs_pkg::LABEL_W-1:0]       i_label,
    input  logic [dtcs_pkg::VAL_IN_W-1:0]      i_cell_value,
    input  logic [dtcs_pkg::IDX_W-1:0]         i_cell_index,
    output logic                               o_push,
    output dtcs_pkg::t_item                    o_item,
    output dtcs_pkg::t_cfg                     o_cfg
);

    logic [dtcs_pkg::DIMC_W-1:0]                        r_dim_count;
    logic [dtcs_pkg::MAX_DIMS-1:0][dtcs_pkg::SIZE_W-1:0] r_size;
    logic [dtcs_pkg::ORDER_W-1:0]                       r_order;
    logic [dtcs_pkg::DIMC_W-1:0]                        dims;
    logic [dtcs_pkg::DIM_W-1:0]                         pos;
    logic                                               bad_dim;
    logic                                               bad_range;
    logic                                               bad_index;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= '0;
            r_size      <= {dtcs_pkg::MAX_DIMS{dtcs_pkg::SIZE_W'(1)}};
            r_order     <= dtcs_pkg::ORDER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dtcs_pkg::REG_DIM_COUNT: r_dim_count <= i_cfg_data[dtcs_pkg::DIMC_W-1:0];
                dtcs_pkg::REG_SIZE_0:    r_size[0]   <= i_cfg_data;
                dtcs_pkg::REG_SIZE_1:    r_size[1]   <= i_cfg_data;
                dtcs_pkg::REG_SIZE_2:    r_size[2]   <= i_cfg_data;
                dtcs_pkg::REG_SIZE_3:    r_size[3]   <= i_cfg_data;
                dtcs_pkg::REG_ORDER_MAP: r_order     <= i_cfg_data[dtcs_pkg::ORDER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp to the supported dimension count
    assign dims = (r_dim_count > dtcs_pkg::DIMC_W'(dtcs_pkg::MAX_DIMS))
                ? dtcs_pkg::DIMC_W'(dtcs_pkg::MAX_DIMS) : r_dim_count;

    assign pos       = r_order[{i_dim_id, 1'b0} +: dtcs_pkg::DIM_W];
    assign bad_dim   = ({1'b0, i_dim_id} >= dims) || ({1'b0, pos} >= dims);
    assign bad_range = {1'b0, i_label} >= r_size[pos];
    assign bad_index = 32'(i_cell_index) >= dtcs_pkg::CELL_DEPTH;

    always_comb begin
        o_item.action = i_action;
        o_item.pos    = pos;
        o_item.label  = i_label;
        o_item.value  = i_cell_value;
        o_item.index  = i_cell_index;
        o_item.status = dtcs_pkg::ST_OK;
        case (i_action)
            dtcs_pkg::ACT_SET: begin
                if (bad_dim) begin
                    o_item.status = dtcs_pkg::ST_BADDIM;
                end else if (bad_range) begin
                    o_item.status = dtcs_pkg::ST_RANGE;
                end
            end
            dtcs_pkg::ACT_READ: begin
                if (bad_index) begin
                    o_item.status = dtcs_pkg::ST_INDEX;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_push = i_start && !i_busy;

    assign o_cfg.dims  = dims;
    assign o_cfg.sizes = r_size;

endmodule

// File: rtl/core/dtcs_queue.sv
// short item queue between the front and back ends
// depends on dtcs_pkg
module dtcs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtcs_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output dtcs_pkg::t_item o_item,
    output logic            o_full
);

    dtcs_pkg::t_item             r_slot [dtcs_pkg::Q_DEPTH];
    logic [dtcs_pkg::QPTR_W-1:0] r_wptr;
    logic [dtcs_pkg::QPTR_W-1:0] r_rptr;
    logic [dtcs_pkg::QCNT_W-1:0] r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == dtcs_pkg::QCNT_W'(dtcs_pkg::Q_DEPTH);
    assign o_item  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/dtcs_back.sv
// back end: pending labels, address walk, cell memory with clearing sweep
// depends on dtcs_pkg and dense_tensor_cell_scatter_assert.svh
`include "dense_tensor_cell_scatter_assert.svh"

module dtcs_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dtcs_pkg::t_cfg                     i_cfg,
    input  logic                               i_q_valid,
    input  dtcs_pkg::t_item                    i_q_item,
    output logic                               o_pop,
    output logic                               o_busy,
    output logic                               o_strobe,
    output logic [dtcs_pkg::STAT_W-1:0]        o_status,
    output logic [dtcs_pkg::IDX_W-1:0]         o_flat_address,
    output logic [dtcs_pkg::VAL_IN_W-1:0]      o_read_value
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_RDOUT = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;

    localparam int PROD_W = dtcs_pkg::LABEL_W + dtcs_pkg::SPAN_W + 1;
    localparam int SPR_W  = dtcs_pkg::SPAN_W + dtcs_pkg::SIZE_W;
    localparam logic [dtcs_pkg::ADDR_W-1:0] SWEEP_LAST =
        dtcs_pkg::ADDR_W'(dtcs_pkg::CELL_DEPTH - 1);

    logic [2:0]                                      r_state;
    dtcs_pkg::t_item                                 r_item;
    logic [dtcs_pkg::LABEL_W-1:0]                    r_label [dtcs_pkg::MAX_DIMS];
    logic [dtcs_pkg::MAX_DIMS-1:0]                   r_lvalid;
    logic [dtcs_pkg::CNT_W-1:0]                      r_cnt;
    logic [dtcs_pkg::SPAN_W-1:0]                     r_addr;
    logic [dtcs_pkg::SPAN_W-1:0]                     r_stride;
    logic                                            r_ovf;
    logic [dtcs_pkg::ADDR_W-1:0]                     r_sweep;
    logic                                            r_emit;
    logic [dtcs_pkg::VALUE_BITS-1:0]                 r_mem [dtcs_pkg::CELL_DEPTH];
    logic [dtcs_pkg::VALUE_BITS-1:0]                 r_mem_q;
    logic                                            r_strobe;
    logic [dtcs_pkg::STAT_W-1:0]                     r_status;
    logic [dtcs_pkg::IDX_W-1:0]                      r_flat;
    logic [dtcs_pkg::VAL_IN_W-1:0]                   r_rval;

    logic [dtcs_pkg::DIM_W-1:0]                      cur;
    logic [PROD_W-1:0]                               sum;
    logic [SPR_W-1:0]                                sprod;
    logic [dtcs_pkg::SPAN_W-1:0]                     n_stride;
    logic                                            n_strobe;
    logic                                            mem_we;
    logic [dtcs_pkg::ADDR_W-1:0]                     mem_waddr;
    logic [dtcs_pkg::VALUE_BITS-1:0]                 mem_wdata;

    // one sorted dimension per walk step, last one first
    assign cur   = dtcs_pkg::DIM_W'(r_cnt - 1'b1);
    assign sum   = PROD_W'(r_addr) + PROD_W'(r_label[cur]) * PROD_W'(r_stride);
    assign sprod = SPR_W'(r_stride) * SPR_W'(i_cfg.sizes[cur]);
    assign n_stride = (32'(sprod) >= dtcs_pkg::CELL_DEPTH)
                    ? dtcs_pkg::SPAN_W'(dtcs_pkg::CELL_DEPTH) : sprod[dtcs_pkg::SPAN_W-1:0];

    assign o_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_busy = r_state != S_IDLE;

    assign mem_we    = (r_state == S_SWEEP) || ((r_state == S_STORE) && !r_ovf);
    assign mem_waddr = (r_state == S_SWEEP) ? r_sweep : r_addr[dtcs_pkg::ADDR_W-1:0];
    assign mem_wdata = (r_state == S_SWEEP) ? '0 : r_item.value[dtcs_pkg::VALUE_BITS-1:0];

    // result beat issued in the cycle after these conditions
    always_comb begin
        case (r_state)
            S_IDLE: begin
                n_strobe = i_q_valid && ((i_q_item.action == dtcs_pkg::ACT_SET) ||
                    ((i_q_item.action == dtcs_pkg::ACT_READ) &&
                     (i_q_item.status != dtcs_pkg::ST_OK)));
            end
            S_WALK:  n_strobe = (r_cnt != '0) && !r_lvalid[cur];
            S_STORE: n_strobe = 1'b1;
            S_RDOUT: n_strobe = 1'b1;
            S_SWEEP: n_strobe = r_emit && (r_sweep == SWEEP_LAST);
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[r_item.index[dtcs_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_sweep  <= '0;
            r_emit   <= 1'b0;
            r_lvalid <= '0;
            r_strobe <= 1'b0;
            for (int d = 0; d < dtcs_pkg::MAX_DIMS; d++) begin
                r_label[d] <= '0;
            end
        end else begin
            r_strobe <= n_strobe;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        r_flat <= '0;
                        r_rval <= '0;
                        case (i_q_item.action)
                            dtcs_pkg::ACT_SET: begin
                                if (i_q_item.status != dtcs_pkg::ST_OK) begin
                                    r_status <= i_q_item.status;
                                end else if (r_lvalid[i_q_item.pos]) begin
                                    r_status <= dtcs_pkg::ST_TWICE;
                                end else begin
                                    r_status                <= dtcs_pkg::ST_OK;
                                    r_label[i_q_item.pos]   <= i_q_item.label;
                                    r_lvalid[i_q_item.pos]  <= 1'b1;
                                end
                            end
                            dtcs_pkg::ACT_WRITE: begin
                                r_cnt    <= dtcs_pkg::CNT_W'(i_cfg.dims);
                                r_addr   <= '0;
                                r_stride <= dtcs_pkg::SPAN_W'(1);
                                r_ovf    <= 1'b0;
                                r_state  <= S_WALK;
                            end
                            dtcs_pkg::ACT_READ: begin
                                if (i_q_item.status != dtcs_pkg::ST_OK) begin
                                    r_status <= i_q_item.status;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_lvalid <= '0;
                                for (int d = 0; d < dtcs_pkg::MAX_DIMS; d++) begin
                                    r_label[d] <= '0;
                                end
                                r_sweep <= '0;
                                r_emit  <= 1'b1;
                                r_state <= S_SWEEP;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_cnt == '0) begin
                        r_state <= S_STORE;
                    end else if (!r_lvalid[cur]) begin
                        r_status <= dtcs_pkg::ST_MISSING;
                        r_state  <= S_IDLE;
                    end else begin
                        if (32'(sum) >= dtcs_pkg::CELL_DEPTH) begin
                            r_ovf <= 1'b1;
                        end
                        r_addr        <= sum[dtcs_pkg::SPAN_W-1:0];
                        r_stride      <= n_stride;
                        r_lvalid[cur] <= 1'b0;
                        r_label[cur]  <= '0;
                        r_cnt         <= r_cnt - 1'b1;
                    end
                end
                S_STORE: begin
                    if (r_ovf) begin
                        r_status <= dtcs_pkg::ST_INDEX;
                    end else begin
                        r_status <= dtcs_pkg::ST_OK;
                        r_flat   <= dtcs_pkg::IDX_W'(r_addr[dtcs_pkg::ADDR_W-1:0]);
                    end
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    r_state <= S_RDOUT;
                end
                S_RDOUT: begin
                    r_status <= dtcs_pkg::ST_OK;
                    r_rval   <= dtcs_pkg::VAL_IN_W'(r_mem_q);
                    r_state  <= S_IDLE;
                end
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == SWEEP_LAST) begin
                        r_status <= dtcs_pkg::ST_OK;
                        r_flat   <= '0;
                        r_rval   <= '0;
                        r_emit   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_flat_address = r_flat;
    assign o_read_value   = r_rval;

    `DTCS_ASSERT_SAME(a_err_zero, i_clk, i_rst_n,
        r_strobe && (r_status != dtcs_pkg::ST_OK),
        (r_flat == '0) && (r_rval == '0), "failed result carries a payload")
    `DTCS_ASSERT_SAME(a_one_item, i_clk, i_rst_n, r_state != S_IDLE, !i_q_valid,
        "item queued while the back end is working")
    `DTCS_ASSERT_NEXT(a_sweep_runs, i_clk, i_rst_n,
        (r_state == S_SWEEP) && (r_sweep != SWEEP_LAST), r_state == S_SWEEP,
        "clearing sweep left early")
    `DTCS_ASSERT_NEXT(a_walk_exit, i_clk, i_rst_n,
        (r_state == S_WALK) && (r_cnt == '0), (r_state == S_STORE) && !r_strobe,
        "address walk did not hand over to the store")

endmodule

// File: rtl/core/dense_tensor_cell_scatter.sv
// top level of the dense tensor cell scatter: front end, queue, back end
// depends on dtcs_pkg, dtcs_front, dtcs_queue, dtcs_back
//
// channel   direction  handshake                 payload
// command   in         start && !busy            i_action i_dim_id i_label
//                                                i_cell_value i_cell_index
// result    out        o_strobe, one cycle       o_status o_flat_address o_read_value
// config    in         i_cfg_valid && o_cfg_ready  i_cfg_index i_cfg_data
//
// set label answers straight from idle, read cell passes the read and read-out
// states, write cell the one-dimension-per-cycle address walk and the store
// clear all runs a clearing sweep over every entry of the cell memory, one
// entry per cycle; the same sweep runs after reset with no result, busy high
// one item in flight at a time; config beats are taken in every cycle
// results cannot be stalled
module dense_tensor_cell_scatter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [dtcs_pkg::ACT_W-1:0]         i_action,
    input  logic [dtcs_pkg::DIM_W-1:0]         i_dim_id,
    input  logic [dtcs_pkg::LABEL_W-1:0]       i_label,
    input  logic [dtcs_pkg::VAL_IN_W-1:0]      i_cell_value,
    input  logic [dtcs_pkg::IDX_W-1:0]         i_cell_index,
    output logic                               o_strobe,
    output logic [dtcs_pkg::STAT_W-1:0]        o_status,
    output logic [dtcs_pkg::IDX_W-1:0]         o_flat_address,
    output logic [dtcs_pkg::VAL_IN_W-1:0]      o_read_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dtcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dtcs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic            push;
    dtcs_pkg::t_item front_item;
    dtcs_pkg::t_cfg  cfg;
    logic            q_valid;
    dtcs_pkg::t_item q_item;
    logic            q_full;
    logic            pop;
    logic            back_busy;

    assign busy = q_valid || q_full || back_busy;

    dtcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_start      (start),
        .i_busy       (busy),
        .i_action     (i_action),
        .i_dim_id     (i_dim_id),
        .i_label      (i_label),
        .i_cell_value (i_cell_value),
        .i_cell_index (i_cell_index),
        .o_push       (push),
        .o_item       (front_item),
        .o_cfg        (cfg)
    );

    dtcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_full  (q_full)
    );

    dtcs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_flat_address (o_flat_address),
        .o_read_value   (o_read_value)
    );

endmodule

// File: verif/dense_tensor_cell_scatter_tb.sv
// self-checking testbench for dense_tensor_cell_scatter: queued driver, result monitor, predictor
// depends on dtcs_pkg and the dense_tensor_cell_scatter rtl
module dense_tensor_cell_scatter_tb;
    import dtcs_pkg::*;

    typedef struct {
        logic [ACT_W-1:0]    action;
        logic [DIM_W-1:0]    dim_id;
        logic [LABEL_W-1:0]  label;
        logic [VAL_IN_W-1:0] value;
        logic [IDX_W-1:0]    index;
        int                  gap;
    } t_tensor_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [IDX_W-1:0]    flat_address;
        logic [VAL_IN_W-1:0] read_value;
    } t_cell_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ACT_W-1:0]      i_action = '0;
    logic [DIM_W-1:0]      i_dim_id = '0;
    logic [LABEL_W-1:0]    i_label = '0;
    logic [VAL_IN_W-1:0]   i_cell_value = '0;
    logic [IDX_W-1:0]      i_cell_index = '0;
    logic                  o_strobe;
    logic [STAT_W-1:0]     o_status;
    logic [IDX_W-1:0]      o_flat_address;
    logic [VAL_IN_W-1:0]   o_read_value;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of registers, pending labels and cell memory
    logic [DIMC_W-1:0]     cfg_dims;
    logic [SIZE_W-1:0]     cfg_size [MAX_DIMS];
    logic [ORDER_W-1:0]    cfg_order;
    logic [LABEL_W-1:0]    held_label [MAX_DIMS];
    logic                  held_valid [MAX_DIMS];
    logic [VAL_IN_W-1:0]   cell_mem [CELL_DEPTH];

    t_tensor_cmd           cmd_queue [$];
    t_tensor_cmd           cur_cmd;
    t_cell_result          expected_results [$];
    t_cell_result          due;
    int                    items_queued = 0;
    int                    items_accepted = 0;
    int                    wait_cnt = 0;
    int                    burst_left = 0;
    int                    fail_count = 0;

    dense_tensor_cell_scatter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_dim_id       (i_dim_id),
        .i_label        (i_label),
        .i_cell_value   (i_cell_value),
        .i_cell_index   (i_cell_index),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_flat_address (o_flat_address),
        .o_read_value   (o_read_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_tensor();
        for (int d = 0; d < MAX_DIMS; d++) begin
            held_label[d] = '0;
            held_valid[d] = 1'b0;
        end
        for (int a = 0; a < CELL_DEPTH; a++) cell_mem[a] = '0;
    endfunction

    function automatic int dims_active();
        return (int'(cfg_dims) > MAX_DIMS) ? MAX_DIMS : int'(cfg_dims);
    endfunction

    function automatic t_cell_result predict_cell_op(input t_tensor_cmd c);
        t_cell_result    r;
        int              n;
        int              pos;
        longint unsigned addr;
        longint unsigned stride;
        bit              missing;
        r = '0;
        n = dims_active();
        case (c.action)
            ACT_SET: begin
                pos = int'(cfg_order[2 * c.dim_id +: 2]);
                if (int'(c.dim_id) >= n || pos >= n) begin
                    r.status = ST_BADDIM;
                end else if (SIZE_W'(c.label) >= cfg_size[pos]) begin
                    r.status = ST_RANGE;
                end else if (held_valid[pos]) begin
                    r.status = ST_TWICE;
                end else begin
                    held_label[pos] = c.label;
                    held_valid[pos] = 1'b1;
                end
            end
            ACT_WRITE: begin
                addr = 0;
                stride = 1;
                missing = 1'b0;
                // fastest dimension first, each label consumed as it is used
                for (int i = n - 1; i >= 0 && !missing; i--) begin
                    if (!held_valid[i]) begin
                        missing = 1'b1;
                    end else begin
                        addr += 64'(held_label[i]) * stride;
                        stride *= 64'(cfg_size[i]);
                        held_valid[i] = 1'b0;
                        held_label[i] = '0;
                    end
                end
                if (missing) begin
                    r.status = ST_MISSING;
                end else if (addr >= 64'(CELL_DEPTH)) begin
                    r.status = ST_INDEX;
                end else begin
                    cell_mem[addr[ADDR_W-1:0]] = c.value;
                    r.flat_address = addr[IDX_W-1:0];
                end
            end
            ACT_READ: begin
                if (int'(c.index) >= CELL_DEPTH) r.status = ST_INDEX;
                else r.read_value = cell_mem[c.index];
            end
            default: clear_tensor();
        endcase
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    task automatic queue_cmd(input logic [ACT_W-1:0] act, input logic [DIM_W-1:0] dim,
                             input logic [LABEL_W-1:0] lab, input logic [VAL_IN_W-1:0] val,
                             input logic [IDX_W-1:0] idx);
        t_tensor_cmd c;
        c.action = act;
        c.dim_id = dim;
        c.label = lab;
        c.value = val;
        c.index = idx;
        if (burst_left > 0) begin
            c.gap = 0;
            burst_left--;
        end else begin
            c.gap = int'($urandom_range(0, 15));
            if ($urandom_range(0, 15) == 0) burst_left = int'($urandom_range(8, 32));
        end
        cmd_queue.insert(cmd_queue.size(), c);
        items_queued++;
    endtask

    task automatic wait_for_idle();
        @(posedge i_clk);
        while (items_accepted != items_queued || expected_results.size() != 0 || busy)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_DIM_COUNT: cfg_dims = data[DIMC_W-1:0];
            REG_SIZE_0:    cfg_size[0] = data;
            REG_SIZE_1:    cfg_size[1] = data;
            REG_SIZE_2:    cfg_size[2] = data;
            REG_SIZE_3:    cfg_size[3] = data;
            REG_ORDER_MAP: cfg_order = data[ORDER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [DIMC_W-1:0] dims, input logic [SIZE_W-1:0] s0,
                                input logic [SIZE_W-1:0] s1, input logic [SIZE_W-1:0] s2,
                                input logic [SIZE_W-1:0] s3, input logic [ORDER_W-1:0] order);
        wait_for_idle();
        write_reg(REG_DIM_COUNT, CFG_DATA_W'(dims));
        write_reg(REG_SIZE_0, s0);
        write_reg(REG_SIZE_1, s1);
        write_reg(REG_SIZE_2, s2);
        write_reg(REG_SIZE_3, s3);
        write_reg(REG_ORDER_MAP, CFG_DATA_W'(order));
        i_cfg_valid <= 1'b0;
    endtask

    // command driver: one beat per start && !busy, gaps drawn per item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                expected_results.insert(expected_results.size(), predict_cell_op(cur_cmd));
                items_accepted++;
                wait_cnt = 0;
            end
            if (cmd_queue.size() != 0 && wait_cnt >= cmd_queue[0].gap) begin
                cur_cmd = cmd_queue.pop_front();
                start <= 1'b1;
                i_action <= cur_cmd.action;
                i_dim_id <= cur_cmd.dim_id;
                i_label <= cur_cmd.label;
                i_cell_value <= cur_cmd.value;
                i_cell_index <= cur_cmd.index;
                wait_cnt = 0;
            end else begin
                start <= 1'b0;
                if (cmd_queue.size() != 0) wait_cnt++;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result beat: status %0d addr %0d value %h",
                                       o_status, o_flat_address, o_read_value));
            end else begin
                due = expected_results.pop_front();
                if (o_status !== due.status || o_flat_address !== due.flat_address ||
                    o_read_value !== due.read_value) begin
                    note_failure($sformatf({"result mismatch: expected status %0d addr %0d ",
                                            "value %h, got status %0d addr %0d value %h"},
                                           due.status, due.flat_address, due.read_value,
                                           o_status, o_flat_address, o_read_value));
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("dense_tensor_cell_scatter verification failed");
        $finish;
    end

    initial begin
        int              d;
        int              j;
        int              tmp;
        int              k;
        int              n;
        int              pick;
        int              drop;
        int              pos;
        int              hi;
        int              r;
        int              span;
        int              perm [MAX_DIMS];
        logic [DIMC_W-1:0] dims;
        logic [SIZE_W-1:0] sizes [MAX_DIMS];
        logic [ORDER_W-1:0] order;
        logic [LABEL_W-1:0] lab;
        longint unsigned prod;

        cfg_dims = '0;
        for (d = 0; d < MAX_DIMS; d++) cfg_size[d] = SIZE_W'(1);
        cfg_order = ORDER_RESET;
        clear_tensor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: scalar cell
        queue_cmd(ACT_WRITE, 2'd0, 10'd0, '1, 10'd0);
        queue_cmd(ACT_READ, 2'd0, 10'd0, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd0, 10'd0, '0, 10'd0);
        queue_cmd(ACT_CLEAR, 2'd0, 10'd0, '0, 10'd0);
        queue_cmd(ACT_READ, 2'd0, 10'd0, '0, 10'd0);

        // four dims, reversed order map
        program_regs(3'd4, 11'd4, 11'd2, 11'd8, 11'd16, 8'b00_01_10_11);
        queue_cmd(ACT_SET, 2'd0, 10'd15, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd0, 10'd3, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd0, 10'd16, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd1, 10'd7, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd2, 10'd1, '0, 10'd0);
        queue_cmd(ACT_WRITE, 2'd0, 10'd0, '1, 10'd0);
        queue_cmd(ACT_SET, 2'd3, 10'd3, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd2, 10'd1, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd1, 10'd7, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd0, 10'd15, '0, 10'd0);
        queue_cmd(ACT_WRITE, 2'd3, 10'd1023, '0, 10'd1023);
        queue_cmd(ACT_READ, 2'd0, 10'd0, '0, 10'd1023);
        queue_cmd(ACT_READ, 2'd0, 10'd0, '0, 10'd0);

        // dim count beyond the limit, address past the store
        program_regs(3'd7, 11'd1024, 11'd1024, 11'd1, 11'd1, ORDER_RESET);
        queue_cmd(ACT_SET, 2'd0, 10'd1023, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd1, 10'd1023, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd2, 10'd0, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd3, 10'd0, '0, 10'd0);
        queue_cmd(ACT_WRITE, 2'd0, 10'd0, '1, 10'd0);

        // zero size and bad dimensions
        program_regs(3'd2, 11'd0, 11'd2047, 11'd1, 11'd1, 8'hfc);
        queue_cmd(ACT_SET, 2'd0, 10'd0, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd1, 10'd5, '0, 10'd0);
        queue_cmd(ACT_SET, 2'd2, 10'd0, '0, 10'd0);

        // random phases
        while (items_queued < 500) begin
            r = int'($urandom_range(0, 9));
            if (r == 0) dims = 3'd0;
            else if (r == 1) dims = DIMC_W'($urandom_range(5, 7));
            else dims = DIMC_W'($urandom_range(1, 4));
            for (d = 0; d < MAX_DIMS; d++) begin
                r = int'($urandom_range(0, 19));
                if (r == 0) sizes[d] = '0;
                else if (r == 1) sizes[d] = SIZE_W'($urandom_range(9, 2047));
                else if (r == 2) sizes[d] = SIZE_W'(1024);
                else sizes[d] = SIZE_W'($urandom_range(1, 8));
                perm[d] = d;
            end
            n = (int'(dims) > MAX_DIMS) ? MAX_DIMS : int'(dims);
            for (d = n - 1; d > 0; d--) begin
                j = int'($urandom_range(0, d));
                tmp = perm[d];
                perm[d] = perm[j];
                perm[j] = tmp;
            end
            order = {perm[3][1:0], perm[2][1:0], perm[1][1:0], perm[0][1:0]};
            if ($urandom_range(0, 4) == 0) order = ORDER_W'($urandom);
            program_regs(dims, sizes[0], sizes[1], sizes[2], sizes[3], order);

            n = dims_active();
            prod = 1;
            for (d = 0; d < n; d++) prod *= 64'(cfg_size[d]);
            span = (prod > 64'(CELL_DEPTH)) ? CELL_DEPTH : int'(prod);

            for (k = 0; k < 60 && items_queued < 500; k++) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 65) begin
                    // one coordinate in random label order, now and then a label dropped
                    for (d = 0; d < MAX_DIMS; d++) perm[d] = d;
                    for (d = n - 1; d > 0; d--) begin
                        j = int'($urandom_range(0, d));
                        tmp = perm[d];
                        perm[d] = perm[j];
                        perm[j] = tmp;
                    end
                    drop = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1;
                    for (d = 0; d < n; d++) begin
                        if (d != drop) begin
                            pos = int'(cfg_order[2 * perm[d] +: 2]);
                            hi = (int'(cfg_size[pos]) > 1024) ? 1023 : int'(cfg_size[pos]) - 1;
                            if (hi < 0 || $urandom_range(0, 19) == 0) lab = LABEL_W'($urandom);
                            else lab = LABEL_W'($urandom_range(0, hi));
                            queue_cmd(ACT_SET, DIM_W'(perm[d]), lab, {$urandom, $urandom},
                                      IDX_W'($urandom));
                        end
                    end
                    queue_cmd(ACT_WRITE, DIM_W'($urandom), LABEL_W'($urandom),
                              {$urandom, $urandom}, IDX_W'($urandom));
                end else if (pick < 82) begin
                    if (span > 0 && $urandom_range(0, 3) != 0)
                        queue_cmd(ACT_READ, DIM_W'($urandom), LABEL_W'($urandom),
                                  {$urandom, $urandom}, IDX_W'($urandom_range(0, span - 1)));
                    else
                        queue_cmd(ACT_READ, DIM_W'($urandom), LABEL_W'($urandom),
                                  {$urandom, $urandom}, IDX_W'($urandom));
                end else if (pick < 95) begin
                    queue_cmd(ACT_SET, DIM_W'($urandom), LABEL_W'($urandom),
                              {$urandom, $urandom}, IDX_W'($urandom));
                end else if (pick < 99) begin
                    queue_cmd(ACT_WRITE, DIM_W'($urandom), LABEL_W'($urandom),
                              {$urandom, $urandom}, IDX_W'($urandom));
                end else begin
                    queue_cmd(ACT_CLEAR, DIM_W'($urandom), LABEL_W'($urandom),
                              {$urandom, $urandom}, IDX_W'($urandom));
                end
            end
        end

        wait_for_idle();
        if (fail_count == 0) begin
            $display("dense_tensor_cell_scatter verification clean");
        end else begin
            $display("dense_tensor_cell_scatter verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dtcs_pkg.sv
rtl/core/dtcs_front.sv
rtl/core/dtcs_queue.sv
rtl/core/dtcs_back.sv
rtl/core/dense_tensor_cell_scatter.sv
verif/dense_tensor_cell_scatter_tb.sv
